[src/asfp_pkg.sv]
package asfp_pkg;

	localparam logic [7:0] HdrFirst   = 8'h2C;
	localparam logic [7:0] HdrSecond  = 8'hE4;
	// index of the checksum byte within the frame (frame is 9 bytes long)
	localparam logic [3:0] ChecksumIdx = 4'd8;
	localparam logic [3:0] FirstDataIdx = 4'd2;

	localparam int unsigned ReadingW = 16;
	localparam int unsigned PayloadW = 3 * ReadingW;

	// outcome of one byte, handed from the parser to the result register
	typedef struct packed {
		logic                valid;
		logic                ok;
		logic [ReadingW-1:0] tvoc;
		logic [ReadingW-1:0] ch2o;
		logic [ReadingW-1:0] co2;
	} asfp_result_t;

endpackage

[src/asfp_parser.sv]
module asfp_parser (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    step,
	input  logic [7:0]              rx_byte,
	output asfp_pkg::asfp_result_t  result
);

	typedef enum logic [1:0] {
		PH_HUNT    = 2'd0,
		PH_HDR2    = 2'd1,
		PH_COLLECT = 2'd2
	} phase_t;

	phase_t                         phase_q, phase_d;
	logic [3:0]                     count_q, count_d;
	logic [7:0]                     sum_q, sum_d;
	logic [asfp_pkg::PayloadW-1:0]  payload_q, payload_d;
	logic [asfp_pkg::PayloadW-1:0]  good_q, good_d;
	logic                           ok;
	logic                           emit;

	always_comb begin
		phase_d   = PH_HUNT;
		count_d   = '0;
		sum_d     = '0;
		payload_d = payload_q;
		good_d    = good_q;
		emit      = 1'b0;
		ok        = (sum_q == rx_byte);
		case (phase_q)
			PH_HDR2: begin
				if (rx_byte == asfp_pkg::HdrSecond) begin
					phase_d = PH_COLLECT;
					count_d = asfp_pkg::FirstDataIdx;
					sum_d   = asfp_pkg::HdrFirst + asfp_pkg::HdrSecond;
				end
			end
			PH_COLLECT: begin
				if (count_q < asfp_pkg::ChecksumIdx) begin
					phase_d   = PH_COLLECT;
					count_d   = count_q + 4'd1;
					sum_d     = sum_q + rx_byte;
					payload_d = {payload_q[asfp_pkg::PayloadW-9:0], rx_byte};
				end else begin
					// checksum byte closes the frame
					emit = 1'b1;
					if (ok) begin
						good_d = payload_q;
					end
				end
			end
			default: begin
				// hunting; the unused phase code behaves the same
				if (rx_byte == asfp_pkg::HdrFirst) begin
					phase_d = PH_HDR2;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HUNT;
			count_q <= '0;
			sum_q   <= '0;
			good_q  <= '0;
		end else if (step) begin
			phase_q <= phase_d;
			count_q <= count_d;
			sum_q   <= sum_d;
			good_q  <= good_d;
		end
	end

	// payload is fully rewritten before every use
	always_ff @(posedge clk) begin
		if (step) begin
			payload_q <= payload_d;
		end
	end

	assign result.valid = emit;
	assign result.ok    = emit & ok;
	assign result.tvoc  = good_d[3*asfp_pkg::ReadingW-1:2*asfp_pkg::ReadingW];
	assign result.ch2o  = good_d[2*asfp_pkg::ReadingW-1:asfp_pkg::ReadingW];
	assign result.co2   = good_d[asfp_pkg::ReadingW-1:0];

endmodule

[src/air_sensor_frame_parser_core.sv]
// Frame parser for an air quality sensor on a serial link. Each input
// transaction carries one received byte. The parser hunts for the header
// 0x2C 0xE4 (the byte right after 0x2C must be 0xE4, else hunting resumes),
// then takes six payload bytes and a checksum byte; the checksum must equal
// the 8-bit sum of the first eight frame bytes. On the checksum byte exactly
// one output transaction is produced: tuser is the checksum-ok flag and tdata
// holds the last good TVOC, CH2O and CO2 readings as raw big-endian counts
// (zero until the first good frame). A bad frame keeps the old readings.
// Every other byte produces no output. Rate is one byte per clock, sustained,
// while the output side keeps up; an input byte passes through the input
// register and then the result register on its way to the output transaction.
module air_sensor_frame_parser_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [47:0] m_axis_tdata,   // [15:0] tvoc_milli, [31:16] formaldehyde_milli,
	                                    // [47:32] co2_ppm
	output logic        m_axis_tuser    // [0] frame_ok
);

	logic                   valid_s1;
	logic [7:0]             byte_s1;
	logic                   advance;
	asfp_pkg::asfp_result_t result;

	logic                   out_valid_q;
	logic                   out_ok_q;
	logic [47:0]            out_data_q;

	// byte in the input register moves on unless it closes a frame while the
	// result slot is still held by a stalled transaction
	assign advance       = valid_s1 && (!result.valid || !out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			byte_s1 <= s_axis_tdata;
		end
	end

	asfp_parser u_parser (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (advance),
		.rx_byte (byte_s1),
		.result  (result)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (!out_valid_q || m_axis_tready) begin
			out_valid_q <= advance && result.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && result.valid) begin
			out_ok_q   <= result.ok;
			out_data_q <= {result.co2, result.ch2o, result.tvoc};
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tuser  = out_ok_q;
	assign m_axis_tdata  = out_data_q;

endmodule

[src/asfp_checker.sv]
module asfp_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [47:0] m_axis_tdata,
	input logic        m_axis_tuser
);

	logic        in_xfer;
	logic        out_xfer;
	logic [47:0] last_data_q;

	assign in_xfer  = s_axis_tvalid && s_axis_tready;
	assign out_xfer = m_axis_tvalid && m_axis_tready;

	// readings seen on the last output transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_data_q <= '0;
		end else if (out_xfer) begin
			last_data_q <= m_axis_tdata;
		end
	end

	// a stalled result holds
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
			m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
		else $error("stalled result changed");

	// a failed checksum reports the previous readings
	assert property (@(posedge clk) disable iff (!arst_n)
		out_xfer && !m_axis_tuser |-> m_axis_tdata == last_data_q)
		else $error("bad frame changed readings");

	// a fresh result comes after an accepted input byte, the byte that closed the frame
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> $past(in_xfer, 2))
		else $error("result without closing byte");

	assert property (@(posedge clk)
		!arst_n |-> !m_axis_tvalid)
		else $error("output valid in reset");

endmodule

bind air_sensor_frame_parser_core asfp_checker u_asfp_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tuser  (m_axis_tuser)
);
